// ===== design/wsd_pkg.sv =====
// Package for the WebSocket frame deframer: phase codes, result kinds and header constants.
package wsd_pkg;

	localparam logic [2:0] PH_OPCODE = 3'd0;
	localparam logic [2:0] PH_LENGTH = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_KEY    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_DROPPED = 2'd2;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	localparam logic [7:0] OP_FINAL_TEXT   = 8'd129;
	localparam logic [7:0] OP_FINAL_BINARY = 8'd130;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       is_binary;
		logic       last;
		logic [1:0] kind;
	} wsd_result_t;

endpackage

// ===== design/websocket_frame_deframer.sv =====
// WebSocket frame deframer: splits a byte stream into frames and unmasks payload bytes.
//
// channel  direction  handshake            payload
// in       receive    in_valid / in_stall  stream_byte
// out      send       out_valid/ out_stall data_byte, is_binary, last, kind
//
// One byte is taken every cycle in which in_valid is high and in_stall is low; its result, if any,
// appears in the output register in the cycle after the byte is taken. The frame state is updated in the same cycle.
// arst_n clears the frame state to wait for an opcode byte and empties the
// output register. in_stall is raised only while a result waits in the output
// register and out_stall is high.
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] stream_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       is_binary,
	output logic       last,
	output logic [1:0] kind
);

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [3:0]  hdr_left_q, hdr_left_d;
	logic [31:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  pos_q, pos_d;

	logic                wsd_accept;
	wsd_pkg::wsd_result_t res;
	logic [3:0]          hdr_dec;
	logic [31:0]         len_dec;
	logic [7:0]          key_byte;
	logic                op_ok;
	logic                op_bin;
	logic                fin;

	assign in_stall   = out_valid && out_stall;
	assign wsd_accept = in_valid && !in_stall;

	assign hdr_dec = hdr_left_q - 4'd1;
	assign len_dec = len_q - 32'd1;
	assign fin     = (len_dec == 32'd0);
	assign op_ok   = (opcode_q == wsd_pkg::OP_FINAL_TEXT) ||
	                 (opcode_q == wsd_pkg::OP_FINAL_BINARY);
	assign op_bin  = (opcode_q == wsd_pkg::OP_FINAL_BINARY);

	always_comb begin
		case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		hdr_left_d = hdr_left_q;
		len_d      = len_q;
		key_d      = key_q;
		pos_d      = pos_q;
		res        = '0;

		case (phase_q)
			wsd_pkg::PH_LENGTH: begin
				masked_d = stream_byte[7];
				len_d    = {25'd0, stream_byte[6:0]};
				if (stream_byte[6:0] == wsd_pkg::LEN_EXT16) begin
					len_d      = 32'd0;
					hdr_left_d = wsd_pkg::EXT16_BYTES;
					phase_d    = wsd_pkg::PH_EXTLEN;
				end else if (stream_byte[6:0] == wsd_pkg::LEN_EXT64) begin
					len_d      = 32'd0;
					hdr_left_d = wsd_pkg::EXT64_BYTES;
					phase_d    = wsd_pkg::PH_EXTLEN;
				end else begin
					phase_d = wsd_pkg::PH_DATA;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				len_d      = {len_q[23:0], stream_byte};
				hdr_left_d = hdr_dec;
				if (hdr_dec == 4'd0) begin
					phase_d = wsd_pkg::PH_DATA;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_d      = {key_q[23:0], stream_byte};
				hdr_left_d = hdr_dec;
				if (hdr_dec == 4'd0) begin
					phase_d = wsd_pkg::PH_DATA;
				end
			end
			wsd_pkg::PH_DATA: begin
				pos_d = pos_q + 2'd1;
				len_d = len_dec;
				if (fin) begin
					phase_d = wsd_pkg::PH_OPCODE;
				end
				if (op_ok) begin
					res.valid     = 1'b1;
					res.data_byte = stream_byte ^ (masked_q ? key_byte : 8'd0);
					res.is_binary = op_bin;
					res.last      = fin;
					res.kind      = wsd_pkg::KIND_DATA;
				end else if (fin) begin
					res.valid = 1'b1;
					res.last  = 1'b1;
					res.kind  = wsd_pkg::KIND_DROPPED;
				end
			end
			default: begin
				opcode_d = stream_byte;
				phase_d  = wsd_pkg::PH_LENGTH;
			end
		endcase

		// length known: collect the key if masked, else finish the header
		if (phase_d == wsd_pkg::PH_DATA && phase_q != wsd_pkg::PH_DATA &&
		    phase_q != wsd_pkg::PH_KEY && masked_d) begin
			hdr_left_d = wsd_pkg::KEY_BYTES;
			key_d      = 32'd0;
			phase_d    = wsd_pkg::PH_KEY;
		end

		// header complete: empty frames give a single marker
		if (phase_d == wsd_pkg::PH_DATA && phase_q != wsd_pkg::PH_DATA) begin
			pos_d = 2'd0;
			if (len_d == 32'd0) begin
				phase_d   = wsd_pkg::PH_OPCODE;
				res.valid = 1'b1;
				res.last  = 1'b1;
				if (op_ok) begin
					res.is_binary = op_bin;
					res.kind      = wsd_pkg::KIND_EMPTY;
				end else begin
					res.kind = wsd_pkg::KIND_DROPPED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsd_pkg::PH_OPCODE;
			opcode_q   <= 8'd0;
			masked_q   <= 1'b0;
			hdr_left_q <= 4'd0;
			len_q      <= 32'd0;
			key_q      <= 32'd0;
			pos_q      <= 2'd0;
		end else if (wsd_accept) begin
			phase_q    <= phase_d;
			opcode_q   <= opcode_d;
			masked_q   <= masked_d;
			hdr_left_q <= hdr_left_d;
			len_q      <= len_d;
			key_q      <= key_d;
			pos_q      <= pos_d;
		end
	end

	logic       out_valid_q;
	logic [7:0] data_byte_q;
	logic       is_binary_q;
	logic       last_q;
	logic [1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wsd_accept && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wsd_accept && res.valid) begin
			data_byte_q <= res.data_byte;
			is_binary_q <= res.is_binary;
			last_q      <= res.last;
			kind_q      <= res.kind;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_byte_q;
	assign is_binary = is_binary_q;
	assign last      = last_q;
	assign kind      = kind_q;

endmodule

// ===== tb/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 100ps
// Testbench for the WebSocket frame deframer: directed frames, then random checked streams.
module tb_websocket_frame_deframer;

	typedef struct packed {
		logic [7:0] data;
		logic       is_bin;
		logic       fin;
		logic [1:0] kind;
	} deframed_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		deframed_t  res;
	} stim_row_t;

	localparam deframed_t NO_OUT = '0;

	localparam stim_row_t DIRECTED_ROWS [25] = '{
		'{8'h81, 1'b0, NO_OUT},
		'{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, wsd_pkg::KIND_EMPTY}},
		'{8'h00, 1'b0, NO_OUT},
		'{8'h7f, 1'b0, NO_OUT},
		'{8'hff, 1'b0, NO_OUT},
		'{8'hff, 1'b0, NO_OUT},
		'{8'hff, 1'b0, NO_OUT},
		'{8'hff, 1'b0, NO_OUT},
		'{8'h00, 1'b0, NO_OUT},
		'{8'h00, 1'b0, NO_OUT},
		'{8'h00, 1'b0, NO_OUT},
		'{8'h01, 1'b0, NO_OUT},
		'{8'h55, 1'b1, '{8'h00, 1'b0, 1'b1, wsd_pkg::KIND_DROPPED}},
		'{8'h82, 1'b0, NO_OUT},
		'{8'hfe, 1'b0, NO_OUT},
		'{8'h00, 1'b0, NO_OUT},
		'{8'h02, 1'b0, NO_OUT},
		'{8'hff, 1'b0, NO_OUT},
		'{8'h00, 1'b0, NO_OUT},
		'{8'h0f, 1'b0, NO_OUT},
		'{8'hf0, 1'b0, NO_OUT},
		'{8'hff, 1'b0, NO_OUT},
		'{8'h3c, 1'b0, NO_OUT},
		'{8'hff, 1'b0, NO_OUT},
		'{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, wsd_pkg::KIND_DROPPED}}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] stream_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] data_byte;
	logic       is_binary;
	logic       last;
	logic [1:0] kind;

	logic      row_typed;
	deframed_t row_frame_out;
	deframed_t pending_out [$];
	deframed_t want;
	deframed_t predicted;
	bit        produced;
	int        sent_cnt;
	int        mismatch_cnt;
	bit        calm;
	bit        held_off;
	int        hold_n;

	logic [2:0]  ph;
	logic [7:0]  opc;
	logic        msk;
	logic [3:0]  hdr_left;
	logic [31:0] pay_left;
	logic [31:0] key;
	logic [1:0]  key_pos;

	websocket_frame_deframer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.stream_byte(stream_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.is_binary  (is_binary),
		.last       (last),
		.kind       (kind)
	);

	function automatic bit opc_passes();
		return opc == wsd_pkg::OP_FINAL_TEXT || opc == wsd_pkg::OP_FINAL_BINARY;
	endfunction

	task automatic header_complete(output bit got, output deframed_t r);
		key_pos = 2'd0;
		got = 1'b0;
		r = '0;
		if (pay_left == 32'd0) begin
			ph = wsd_pkg::PH_OPCODE;
			got = 1'b1;
			if (opc_passes())
				r = '{8'h00, opc == wsd_pkg::OP_FINAL_BINARY, 1'b1, wsd_pkg::KIND_EMPTY};
			else
				r = '{8'h00, 1'b0, 1'b1, wsd_pkg::KIND_DROPPED};
		end else begin
			ph = wsd_pkg::PH_DATA;
		end
	endtask

	task automatic length_complete(output bit got, output deframed_t r);
		if (msk) begin
			hdr_left = wsd_pkg::KEY_BYTES;
			key = '0;
			ph = wsd_pkg::PH_KEY;
			got = 1'b0;
			r = '0;
		end else begin
			header_complete(got, r);
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit got, output deframed_t r);
		logic [7:0] kb;
		got = 1'b0;
		r = '0;
		case (ph)
		wsd_pkg::PH_LENGTH: begin
			msk = b[7];
			pay_left = '0;
			if (b[6:0] == wsd_pkg::LEN_EXT16) begin
				hdr_left = wsd_pkg::EXT16_BYTES;
				ph = wsd_pkg::PH_EXTLEN;
			end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
				hdr_left = wsd_pkg::EXT64_BYTES;
				ph = wsd_pkg::PH_EXTLEN;
			end else begin
				pay_left = {25'd0, b[6:0]};
				length_complete(got, r);
			end
		end
		wsd_pkg::PH_EXTLEN: begin
			pay_left = {pay_left[23:0], b};
			hdr_left = hdr_left - 4'd1;
			if (hdr_left == 4'd0)
				length_complete(got, r);
		end
		wsd_pkg::PH_KEY: begin
			key = {key[23:0], b};
			hdr_left = hdr_left - 4'd1;
			if (hdr_left == 4'd0)
				header_complete(got, r);
		end
		wsd_pkg::PH_DATA: begin
			kb = msk ? key[8 * (3 - key_pos) +: 8] : 8'h00;
			key_pos = key_pos + 2'd1;
			pay_left = pay_left - 32'd1;
			if (pay_left == 32'd0)
				ph = wsd_pkg::PH_OPCODE;
			if (opc_passes()) begin
				got = 1'b1;
				r = '{b ^ kb, opc == wsd_pkg::OP_FINAL_BINARY, pay_left == 32'd0,
					wsd_pkg::KIND_DATA};
			end else if (pay_left == 32'd0) begin
				got = 1'b1;
				r = '{8'h00, 1'b0, 1'b1, wsd_pkg::KIND_DROPPED};
			end
		end
		default: begin
			opc = b;
			ph = wsd_pkg::PH_LENGTH;
		end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			mismatch_cnt++;
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic typed, input deframed_t res);
		@(negedge clk);
		calm = sent_cnt >= 1000 && sent_cnt < 1300;
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		row_typed <= typed;
		row_frame_out <= res;
		do @(posedge clk); while (in_stall);
		sent_cnt++;
	endtask

	task automatic send_frame();
		logic [7:0]  frame_q [$];
		logic [31:0] len;
		logic [31:0] mkey;
		logic        masked;
		int          sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			frame_q.push_back(wsd_pkg::OP_FINAL_TEXT);
		else if (sel < 80)
			frame_q.push_back(wsd_pkg::OP_FINAL_BINARY);
		else
			frame_q.push_back(8'($urandom_range(0, 255)));
		masked = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 30);
			frame_q.push_back({masked, len[6:0]});
		end else if (sel < 90) begin
			len = $urandom_range(0, 200);
			frame_q.push_back({masked, wsd_pkg::LEN_EXT16});
			frame_q.push_back(len[15:8]);
			frame_q.push_back(len[7:0]);
		end else begin
			len = $urandom_range(0, 40);
			frame_q.push_back({masked, wsd_pkg::LEN_EXT64});
			repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
			for (int i = 3; i >= 0; i--)
				frame_q.push_back(len[8 * i +: 8]);
		end
		if (masked) begin
			mkey = $urandom;
			for (int i = 3; i >= 0; i--)
				frame_q.push_back(mkey[8 * i +: 8]);
		end
		repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
		foreach (frame_q[i])
			send_byte(frame_q[i], 1'b0, NO_OUT);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_out.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: expected no result, actual data %0h bin %0b last %0b kind %0d",
						$time, data_byte, is_binary, last, kind);
				end else begin
					want = pending_out.pop_front();
					check_field("data_byte", want.data, data_byte);
					check_field("is_binary", {7'd0, want.is_bin}, {7'd0, is_binary});
					check_field("last", {7'd0, want.fin}, {7'd0, last});
					check_field("kind", {6'd0, want.kind}, {6'd0, kind});
				end
			end
			if (in_valid && !in_stall) begin
				deframe_byte(stream_byte, produced, predicted);
				if (row_typed)
					pending_out.push_back(row_frame_out);
				else if (produced)
					pending_out.push_back(predicted);
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		held_off = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && sent_cnt >= 500) begin
				held_off = 1'b1;
				for (hold_n = 0; hold_n < 300; hold_n++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= !calm && $urandom_range(0, 99) < 35;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		stream_byte = 8'h00;
		row_typed = 1'b0;
		row_frame_out = NO_OUT;
		sent_cnt = 0;
		mismatch_cnt = 0;
		calm = 1'b0;
		ph = wsd_pkg::PH_OPCODE;
		opc = '0;
		msk = 1'b0;
		hdr_left = '0;
		pay_left = '0;
		key = '0;
		key_pos = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (DIRECTED_ROWS[i])
			send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
		while (sent_cnt < 1900)
			send_frame();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== websocket_frame_deframer.f =====
design/wsd_pkg.sv
design/websocket_frame_deframer.sv
tb/tb_websocket_frame_deframer.sv
